// ===== hdl/frustum_sphere_cull_macros.svh =====
// Assertion macros used by the frustum culling plane cell.
`ifndef FRUSTUM_SPHERE_CULL_MACROS_SVH
`define FRUSTUM_SPHERE_CULL_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frustum cull assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frustum cull assertion failed");

`endif

// ===== hdl/fsc_pkg.sv =====
// Types, constants and plane derivation shared by the frustum culling block.
`timescale 1ns / 1ps

package fsc_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int WIDE_W = 134;

	typedef logic signed [31:0] entry_t;
	typedef entry_t matrix_t [16];
	typedef logic signed [32:0] coef_t;
	typedef coef_t plane_t [4];

	typedef struct packed {
		logic               valid;
		logic               vis;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [30:0]        r;
	} sphere_t;

	localparam bit PLANE_W3 [PLANE_COUNT] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
	localparam int PLANE_SEL [PLANE_COUNT] = '{0, 0, 1, 1, 2, 2};
	localparam bit PLANE_NEG [PLANE_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

	function automatic coef_t plane_coef(matrix_t m, int k, int col);
		coef_t s;
		coef_t v;
		s = coef_t'(m[col * 4 + PLANE_SEL[k]]);
		v = PLANE_W3[k] ? coef_t'(m[col * 4 + 3]) : '0;
		return PLANE_NEG[k] ? coef_t'(v - s) : coef_t'(v + s);
	endfunction

endpackage

// ===== hdl/fsc_if.sv =====
// Valid/ready channel interfaces for spheres in and visibility flags out.
`timescale 1ns / 1ps

interface sphere_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [31:0] center_z;
	logic [30:0]        radius;

	modport source (output valid, center_x, center_y, center_z, radius, input ready);
	modport sink (input valid, center_x, center_y, center_z, radius, output ready);
endinterface

interface result_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

// ===== hdl/fsc_cell.sv =====
// One plane test cell: six pipeline stages that may clear the visible flag.
`timescale 1ns / 1ps
`include "frustum_sphere_cull_macros.svh"

module fsc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  fsc_pkg::plane_t plane,
	input  fsc_pkg::sphere_t in_item,
	output fsc_pkg::sphere_t out_item
);
	import fsc_pkg::*;

	coef_t        coef_q [4];
	logic [65:0]  sq_q [3];
	logic [65:0]  l2_q;
	logic         nz;

	sphere_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	sphere_t s6_c;
	logic signed [64:0] px_s1, py_s1, pz_s1;
	logic [61:0]        r2_s1, r2_s2, r2_s3;
	logic signed [66:0] sum_s2;
	logic               neg_s3, neg_s4, neg_s5;
	logic [65:0]        mag_s3;
	logic [65:0]        hh_s4, hl_s4, ll_s4;
	logic [63:0]        a_s4, b_s4, c_s4, d_s4;
	logic [WIDE_W-1:0]  s2_s5, rl_s5;
	logic signed [66:0] sum_c;
	logic [32:0]        cmag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cmag[i] = coef_q[i][32] ? 33'(-coef_q[i]) : 33'(coef_q[i]);
		end
		nz = (coef_q[0] != '0) || (coef_q[1] != '0) || (coef_q[2] != '0);
		sum_c = 67'(px_s1) + 67'(py_s1) + 67'(pz_s1);
		s6_c = it_s5;
		s6_c.vis = it_s5.vis & ~(nz & neg_s5 & (s2_s5 > rl_s5));
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			coef_q[i] <= plane[i];
		end
		for (int i = 0; i < 3; i++) begin
			sq_q[i] <= 66'(cmag[i]) * 66'(cmag[i]);
		end
		l2_q <= sq_q[0] + sq_q[1] + sq_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_s1 <= '0;
			it_s2 <= '0;
			it_s3 <= '0;
			it_s4 <= '0;
			it_s5 <= '0;
			it_s6 <= '0;
		end else if (en) begin
			it_s1 <= in_item;
			it_s2 <= it_s1;
			it_s3 <= it_s2;
			it_s4 <= it_s3;
			it_s5 <= it_s4;
			it_s6 <= s6_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= 65'(coef_q[0]) * 65'(in_item.x);
			py_s1 <= 65'(coef_q[1]) * 65'(in_item.y);
			pz_s1 <= 65'(coef_q[2]) * 65'(in_item.z);
			r2_s1 <= 62'(in_item.r) * 62'(in_item.r);

			sum_s2 <= sum_c + 67'($signed({coef_q[3], 16'd0}));
			r2_s2  <= r2_s1;

			neg_s3 <= sum_s2[66];
			mag_s3 <= sum_s2[66] ? 66'(-sum_s2) : 66'(sum_s2);
			r2_s3  <= r2_s2;

			neg_s4 <= neg_s3;
			hh_s4  <= 66'(mag_s3[65:33]) * 66'(mag_s3[65:33]);
			hl_s4  <= 66'(mag_s3[65:33]) * 66'(mag_s3[32:0]);
			ll_s4  <= 66'(mag_s3[32:0]) * 66'(mag_s3[32:0]);
			a_s4   <= 64'(r2_s3[61:31]) * 64'(l2_q[65:33]);
			b_s4   <= 64'(r2_s3[61:31]) * 64'(l2_q[32:0]);
			c_s4   <= 64'(r2_s3[30:0]) * 64'(l2_q[65:33]);
			d_s4   <= 64'(r2_s3[30:0]) * 64'(l2_q[32:0]);

			neg_s5 <= neg_s4;
			s2_s5  <= (WIDE_W'(hh_s4) << 66) + (WIDE_W'(hl_s4) << 34) + WIDE_W'(ll_s4);
			rl_s5  <= (WIDE_W'(a_s4) << 64) + (WIDE_W'(b_s4) << 31)
				+ (WIDE_W'(c_s4) << 33) + WIDE_W'(d_s4);
		end
	end

	assign out_item = it_s6;

	`FSC_ASSERT_NEXT(a_hold, !en, $stable(it_s6))
	`FSC_ASSERT_NEXT(a_no_revive, en && it_s5.valid && !it_s5.vis, !it_s6.vis)
	`FSC_ASSERT_NEXT(a_zero_plane, en && it_s5.valid && it_s5.vis && !nz, it_s6.vis)

endmodule

// ===== hdl/frustum_sphere_cull.sv =====
// Frustum culling of bounding spheres: a user takes one sphere per clock cycle at the sphere
// port and receives one visible flag per sphere at the result port, in order. The six plane
// tests form a chain of cells of six pipeline stages each; the rate of one sphere per cycle is
// set by that pipeline and holds while results are taken, and a two-entry output stage absorbs
// a stalled result port. Planes are derived combinationally from the matrix registers and
// registered inside each cell.
`timescale 1ns / 1ps

module frustum_sphere_cull (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	sphere_if.sink      sphere,
	result_if.source    result
);
	import fsc_pkg::*;

	matrix_t m_q;
	plane_t  planes [PLANE_COUNT];
	sphere_t chain [PLANE_COUNT + 1];
	logic    en;
	logic    out_v_q, out_d_q, skid_v_q, skid_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				m_q[i] <= '0;
			end
		end else if (cfg_we) begin
			m_q[{cfg_index, 1'b0}] <= cfg_data[31:0];
			m_q[{cfg_index, 1'b1}] <= cfg_data[63:32];
		end
	end

	assign en = ~skid_v_q;
	assign sphere.ready = en;

	always_comb begin
		chain[0].valid = sphere.valid;
		chain[0].vis   = 1'b1;
		chain[0].x     = sphere.center_x;
		chain[0].y     = sphere.center_y;
		chain[0].z     = sphere.center_z;
		chain[0].r     = sphere.radius;
	end

	for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
		always_comb begin
			for (int c = 0; c < 4; c++) begin
				planes[k][c] = plane_coef(m_q, k, c);
			end
		end

		fsc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.plane    (planes[k]),
			.in_item  (chain[k]),
			.out_item (chain[k + 1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			out_v_q  <= skid_v_q | (en & chain[PLANE_COUNT].valid);
			skid_v_q <= 1'b0;
		end else if (en && chain[PLANE_COUNT].valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			out_d_q <= skid_v_q ? skid_d_q : chain[PLANE_COUNT].vis;
		end else if (en && chain[PLANE_COUNT].valid) begin
			skid_d_q <= chain[PLANE_COUNT].vis;
		end
	end

	assign result.valid   = out_v_q;
	assign result.visible = out_d_q;

endmodule

// ===== sim/frustum_sphere_cull_tb.sv =====
// Testbench for the frustum sphere culler: matrix phases, directed and random spheres, scoreboard.
`timescale 1ns / 1ps

module frustum_sphere_cull_tb;
	import fsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 45;
	localparam int RANDOM_PER_PHASE = 230;
	localparam int ONE = 65536;
	localparam bit ADD_W_ROW [6] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
	localparam int ROW_OF [6] = '{0, 0, 1, 1, 2, 2};
	localparam bit SUBTRACT [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

	typedef logic signed [31:0] q16_t;

	class cull_board;
		q16_t mtx [16];
		bit pending_vis [$];
		int errors;
		int spheres;
		int culled;

		function bit sphere_visible(q16_t cx, q16_t cy, q16_t cz, logic [30:0] rad);
			logic signed [33:0] n [4];
			logic signed [69:0] sdist;
			logic [69:0] mag;
			logic [139:0] dist_sq;
			logic [139:0] norm_sq;
			logic [139:0] rad_term;
			for (int k = 0; k < 6; k++) begin
				for (int c = 0; c < 4; c++) begin
					n[c] = ADD_W_ROW[k] ? 34'(mtx[c * 4 + 3]) : 34'sd0;
					n[c] = SUBTRACT[k] ? n[c] - mtx[c * 4 + ROW_OF[k]]
						: n[c] + mtx[c * 4 + ROW_OF[k]];
				end
				if (n[0] == 0 && n[1] == 0 && n[2] == 0)
					continue;
				sdist = n[0] * cx + n[1] * cy + n[2] * cz + n[3] * 70'sd65536;
				if (sdist >= 0)
					continue;
				mag = -sdist;
				dist_sq = 140'(mag) * 140'(mag);
				norm_sq = '0;
				for (int c = 0; c < 3; c++) begin
					mag = n[c] < 0 ? -70'(n[c]) : 70'(n[c]);
					norm_sq = norm_sq + 140'(mag) * 140'(mag);
				end
				rad_term = 140'(rad) * 140'(rad) * norm_sq;
				if (dist_sq > rad_term)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_sphere(q16_t cx, q16_t cy, q16_t cz, logic [30:0] rad);
			bit v;
			v = sphere_visible(cx, cy, cz, rad);
			pending_vis.push_back(v);
			spheres++;
			if (!v)
				culled++;
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_flag(logic vis);
			bit want;
			if (pending_vis.size() == 0) begin
				report("visible flag with no sphere outstanding");
				return;
			end
			want = pending_vis.pop_front();
			if (vis !== want)
				report($sformatf("visible got %b, want %b", vis, want));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	bit idling = 1'b1;
	int cycles = 0;
	int stall_left = 0;
	int phases_run = 0;
	cull_board board = new();
	q16_t next_mtx [16];

	sphere_if sph ();
	result_if res ();

	frustum_sphere_cull DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sphere   (sph),
		.result   (res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d flags outstanding", board.pending_vis.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res.valid && res.ready)
				board.check_flag(res.visible);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				res.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 11);
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic send_sphere(q16_t cx, q16_t cy, q16_t cz, logic [30:0] rad);
		if (idling && $urandom_range(0, 5) == 0) begin
			sph.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		sph.valid <= 1'b1;
		sph.center_x <= cx;
		sph.center_y <= cy;
		sph.center_z <= cz;
		sph.radius <= rad;
		do @(posedge clk); while (!sph.ready);
		board.note_sphere(cx, cy, cz, rad);
	endtask

	task automatic load_matrix();
		sph.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_vis.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= {next_mtx[2 * i + 1], next_mtx[2 * i]};
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		board.mtx = next_mtx;
		phases_run++;
		repeat (5) @(posedge clk);
	endtask

	task automatic random_spheres(int count, int span);
		int kind;
		q16_t cx, cy, cz;
		logic [30:0] rad;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				cx = $signed($urandom_range(0, 2 * span)) - span;
				cy = $signed($urandom_range(0, 2 * span)) - span;
				cz = $signed($urandom_range(0, 2 * span)) - span;
				rad = 31'($urandom_range(0, span / 3));
			end else begin
				cx = $urandom();
				cy = $urandom();
				cz = $urandom();
				rad = 31'($urandom());
			end
			send_sphere(cx, cy, cz, rad);
		end
	endtask

	initial begin
		sph.valid = 1'b0;
		sph.center_x = '0;
		sph.center_y = '0;
		sph.center_z = '0;
		sph.radius = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset matrix: every plane has a zero normal, so everything stays visible.
		send_sphere(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff);
		send_sphere(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'h0);
		send_sphere(32'sh0, 32'sh0, 32'sh0, 31'h0);
		send_sphere(32'shffffffff, 32'shffffffff, 32'shffffffff, 31'h1);

		// Identity matrix: the left plane passes through x = -1.
		foreach (next_mtx[i]) next_mtx[i] = (i % 5 == 0) ? ONE : 0;
		load_matrix();
		send_sphere(-3 * ONE, 0, 0, 31'(ONE));
		send_sphere(-3 * ONE - 1, 0, 0, 31'(ONE));
		send_sphere(-3 * ONE + 1, 0, 0, 31'(ONE));
		send_sphere(3 * ONE, 0, 0, 31'(ONE));
		send_sphere(3 * ONE + 1, 0, 0, 31'(ONE));
		send_sphere(0, -2 * ONE - 1, 0, 31'(ONE / 2));
		send_sphere(0, 2 * ONE, 0, 31'(ONE));
		send_sphere(0, 0, -ONE, 31'(0));
		send_sphere(0, 0, -ONE / 2, 31'(ONE / 2));
		send_sphere(0, 0, 2 * ONE, 31'(ONE));
		send_sphere(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff);
		send_sphere(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h0);
		send_sphere(0, 0, 0, 31'h0);
		random_spheres(RANDOM_PER_PHASE, 4 * ONE);

		// Perspective projection looking down -z.
		foreach (next_mtx[i]) next_mtx[i] = 0;
		next_mtx[0] = ONE * 3 / 2;
		next_mtx[5] = ONE * 2;
		next_mtx[10] = -65667;
		next_mtx[11] = -ONE;
		next_mtx[14] = -13107;
		load_matrix();
		random_spheres(RANDOM_PER_PHASE, 40 * ONE);

		foreach (next_mtx[i]) next_mtx[i] = $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
		load_matrix();
		random_spheres(RANDOM_PER_PHASE, 6 * ONE);

		foreach (next_mtx[i]) next_mtx[i] = $urandom();
		load_matrix();
		random_spheres(RANDOM_PER_PHASE, 1 << 28);

		foreach (next_mtx[i]) next_mtx[i] = 32'sh7fffffff;
		load_matrix();
		random_spheres(RANDOM_PER_PHASE / 2, 1 << 29);

		foreach (next_mtx[i]) next_mtx[i] = 32'sh80000000;
		load_matrix();
		random_spheres(RANDOM_PER_PHASE / 2, 1 << 29);

		foreach (next_mtx[i]) next_mtx[i] = (i % 5 == 0) ? ONE : $urandom_range(0, ONE / 4);
		load_matrix();
		random_spheres(RANDOM_PER_PHASE, 4 * ONE);

		// Closing stretch at full rate on both sides.
		idling = 1'b0;
		foreach (next_mtx[i]) next_mtx[i] = 0;
		next_mtx[0] = ONE;
		next_mtx[5] = ONE;
		next_mtx[10] = -65667;
		next_mtx[11] = -ONE;
		next_mtx[14] = -13107;
		load_matrix();
		random_spheres(RANDOM_PER_PHASE, 20 * ONE);

		sph.valid <= 1'b0;
		while (board.pending_vis.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d spheres over %0d matrix settings, %0d of them culled.",
			board.spheres, phases_run, board.culled);
		if (board.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", board.errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
